>>> rtl/core/salc_pkg.sv
`default_nettype none

package salc_pkg;

	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = 32;
	localparam int REQ_ADDR_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

	localparam logic [2:0] SET_BITS_RESET    = 3'd4;
	localparam logic [3:0] WAYS_IN_USE_RESET = 4'd8;
	localparam logic [5:0] OFFSET_BITS_RESET = 6'd4;

	localparam logic [5:0] OFFSET_BITS_MAX = 6'd32;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} salc_state_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [REQ_ADDR_W-1:0] address;
	} salc_in_t;

	typedef struct packed {
		logic             was_hit;
		logic             was_miss;
		logic             was_eviction;
		logic             second_hit;
		logic [CNT_W-1:0] hits_so_far;
		logic [CNT_W-1:0] misses_so_far;
		logic [CNT_W-1:0] evictions_so_far;
	} salc_out_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic evict;
	} salc_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/salc_ram.sv
`default_nettype none

module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/salc_lookup.sv
`default_nettype none

module salc_lookup #(
	parameter int MAX_WAYS = 8,
	parameter int TAG_W    = 62
) (
	input  wire logic [MAX_WAYS*(1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+TAG_W)-1:0] row,
	input  wire logic [TAG_W-1:0]                tag,
	input  wire logic [$clog2(MAX_WAYS+1)-1:0]   ways,
	output logic [MAX_WAYS*(1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+TAG_W)-1:0]      new_row,
	output salc_pkg::salc_flags_t                flags
);

	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W  = $clog2(MAX_WAYS+1);
	localparam int LINE_W = 1 + RANK_W + TAG_W;
	localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);
	localparam logic [CNT_W-1:0]  WAYS_ALL = CNT_W'(MAX_WAYS);

	logic [MAX_WAYS-1:0]    in_use;
	logic [MAX_WAYS-1:0]    valid;
	logic [RANK_W-1:0]      rank [MAX_WAYS];
	logic [TAG_W-1:0]       ltag [MAX_WAYS];
	logic                   hit;
	logic [WAY_W-1:0]       hit_way;
	logic [RANK_W-1:0]      hit_rank;
	logic                   have_free;
	logic [WAY_W-1:0]       free_way;
	logic [CNT_W-1:0]       nvalid;
	logic [RANK_W-1:0]      best;
	logic [WAY_W-1:0]       victim;
	logic [WAY_W-1:0]       sel_way;
	logic [CNT_W-1:0]       old_rank;
	logic [LINE_W-1:0]      line;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = CNT_W'(i) < ways;
			valid[i]  = row[i*LINE_W + LINE_W - 1];
			rank[i]   = row[i*LINE_W + TAG_W +: RANK_W];
			ltag[i]   = row[i*LINE_W +: TAG_W];
		end

		// lowest matching way wins
		hit      = 1'b0;
		hit_way  = '0;
		hit_rank = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && valid[i] && ltag[i] == tag) begin
				hit      = 1'b1;
				hit_way  = WAY_W'(i);
				hit_rank = rank[i];
			end
		end

		// highest invalid way wins
		have_free = 1'b0;
		free_way  = '0;
		nvalid    = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && !valid[i]) begin
				have_free = 1'b1;
				free_way  = WAY_W'(i);
			end
			if (in_use[i] && valid[i]) begin
				nvalid = nvalid + 1'b1;
			end
		end

		// oldest way, lowest index on ties
		best   = '0;
		victim = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && rank[i] > best) begin
				best   = rank[i];
				victim = WAY_W'(i);
			end
		end

		if (hit) begin
			sel_way  = hit_way;
			old_rank = CNT_W'(hit_rank);
		end else if (have_free) begin
			sel_way  = free_way;
			old_rank = nvalid;
		end else begin
			sel_way  = victim;
			old_rank = WAYS_ALL;
		end

		for (int i = 0; i < MAX_WAYS; i++) begin
			line = row[i*LINE_W +: LINE_W];
			if (WAY_W'(i) == sel_way) begin
				line = {1'b1, {RANK_W{1'b0}}, tag};
			end else if (in_use[i] && valid[i] && CNT_W'(rank[i]) < old_rank
					&& rank[i] < RANK_TOP) begin
				line[TAG_W +: RANK_W] = rank[i] + 1'b1;
			end
			new_row[i*LINE_W +: LINE_W] = line;
		end

		flags.hit   = hit;
		flags.miss  = !hit;
		flags.evict = !hit && !have_free;
	end

endmodule

`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_sim.sv
`default_nettype none

// result strobe (done) is registered from the lookup state that follows an accepted request
// a new request is taken only in idle, not during a lookup: set row read, then compare and write back of the row
// a modify is handled within the same single lookup
// asynchronous reset; afterwards busy stays high while
// every set row is cleared
// done is high for one cycle only and result holds until the next lookup; the receiver cannot stall

module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire salc_pkg::salc_in_t                  req,
	output logic                                     done,
	output salc_pkg::salc_out_t                      result,
	input  wire logic                                wr_en,
	input  wire logic [salc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [salc_pkg::CFG_W-1:0]          wr_data
);

	localparam int SET_W    = MAX_SET_BITS;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int TAG_W    = ADDR_WIDTH - 2;
	localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LINE_W   = 1 + RANK_W + TAG_W;
	localparam int ROW_W    = MAX_WAYS * LINE_W;
	localparam int WCNT_W   = $clog2(MAX_WAYS+1);
	localparam int SHAMT_W  = 7;
	localparam int CW       = salc_pkg::CNT_W;

	salc_pkg::salc_state_t state_q, state_d;

	logic [2:0]              set_bits_q;
	logic [3:0]              ways_q;
	logic [5:0]              offset_q;

	logic [2:0]              s_sat;
	logic [5:0]              o_sat;
	logic [WCNT_W-1:0]       w_sat;
	logic [ADDR_WIDTH-1:0]   addr_m;
	logic [ADDR_WIDTH-1:0]   addr_off;
	logic [SET_W-1:0]        set_mask;
	logic [SET_W-1:0]        set_idx;
	logic [SHAMT_W-1:0]      tag_shamt;
	logic [TAG_W-1:0]        tag_val;

	logic [SET_W-1:0]        set_s1;
	logic [TAG_W-1:0]        tag_s1;
	logic [1:0]              req_s1;
	logic [WCNT_W-1:0]       ways_s1;

	logic [SET_W-1:0]        clr_q;
	logic                    accept;
	logic                    ram_we;
	logic [SET_W-1:0]        ram_waddr;
	logic [ROW_W-1:0]        ram_wdata;
	logic [ROW_W-1:0]        row;
	logic [ROW_W-1:0]        new_row;
	salc_pkg::salc_flags_t   flags;

	logic                    req_ok;
	logic                    is_modify;
	logic [1:0]              hit_inc;
	logic [CW:0]             hit_sum;
	logic [CW:0]             miss_sum;
	logic [CW:0]             evict_sum;
	logic [CW-1:0]           hit_cnt_q;
	logic [CW-1:0]           miss_cnt_q;
	logic [CW-1:0]           evict_cnt_q;
	logic [CW-1:0]           hit_next;
	logic [CW-1:0]           miss_next;
	logic [CW-1:0]           evict_next;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= salc_pkg::SET_BITS_RESET;
			ways_q     <= salc_pkg::WAYS_IN_USE_RESET;
			offset_q   <= salc_pkg::OFFSET_BITS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				salc_pkg::REG_SET_BITS:    set_bits_q <= wr_data[2:0];
				salc_pkg::REG_WAYS_IN_USE: ways_q     <= wr_data[3:0];
				salc_pkg::REG_OFFSET_BITS: offset_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// address split
	always_comb begin
		if (set_bits_q == '0) begin
			s_sat = 3'd1;
		end else if (32'(set_bits_q) > MAX_SET_BITS) begin
			s_sat = 3'(MAX_SET_BITS);
		end else begin
			s_sat = set_bits_q;
		end

		if (offset_q == '0) begin
			o_sat = 6'd1;
		end else if (offset_q > salc_pkg::OFFSET_BITS_MAX) begin
			o_sat = salc_pkg::OFFSET_BITS_MAX;
		end else begin
			o_sat = offset_q;
		end

		if (ways_q == '0) begin
			w_sat = WCNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			w_sat = WCNT_W'(MAX_WAYS);
		end else begin
			w_sat = WCNT_W'(ways_q);
		end

		addr_m    = req.address[ADDR_WIDTH-1:0];
		addr_off  = addr_m >> o_sat;
		set_mask  = ~({SET_W{1'b1}} << s_sat);
		set_idx   = addr_off[SET_W-1:0] & set_mask;
		tag_shamt = SHAMT_W'(o_sat) + SHAMT_W'(s_sat);
		tag_val   = TAG_W'(addr_m >> tag_shamt);
	end

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1  <= set_idx;
			tag_s1  <= tag_val;
			req_s1  <= req.req_type;
			ways_s1 <= w_sat;
		end
	end

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (set_idx),
		.rdata (row)
	);

	salc_lookup #(
		.MAX_WAYS (MAX_WAYS),
		.TAG_W    (TAG_W)
	) u_lookup (
		.row     (row),
		.tag     (tag_s1),
		.ways    (ways_s1),
		.new_row (new_row),
		.flags   (flags)
	);

	always_comb begin
		req_ok = 1'b0;
		case (req_s1) inside
			salc_pkg::REQ_LOAD, salc_pkg::REQ_STORE, salc_pkg::REQ_MODIFY: req_ok = 1'b1;
			default: req_ok = 1'b0;
		endcase
	end

	assign is_modify = req_s1 == salc_pkg::REQ_MODIFY;

	// fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = set_s1;
		ram_wdata = new_row;
		unique case (state_q)
			salc_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == SET_W'(NUM_SETS - 1)) begin
					state_d = salc_pkg::ST_IDLE;
				end
			end
			salc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = salc_pkg::ST_LOOKUP;
				end
			end
			salc_pkg::ST_LOOKUP: begin
				ram_we  = req_ok;
				state_d = salc_pkg::ST_IDLE;
			end
			default: state_d = salc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == salc_pkg::ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// saturating totals; the store half of a modify always hits
	always_comb begin
		hit_inc   = '0;
		hit_next  = hit_cnt_q;
		miss_next = miss_cnt_q;
		evict_next = evict_cnt_q;
		if (req_ok) begin
			hit_inc = {1'b0, flags.hit} + {1'b0, is_modify};
		end
		hit_sum   = {1'b0, hit_cnt_q} + (CW+1)'(hit_inc);
		miss_sum  = {1'b0, miss_cnt_q} + (CW+1)'(req_ok && flags.miss);
		evict_sum = {1'b0, evict_cnt_q} + (CW+1)'(req_ok && flags.evict);
		hit_next   = hit_sum[CW]   ? {CW{1'b1}} : hit_sum[CW-1:0];
		miss_next  = miss_sum[CW]  ? {CW{1'b1}} : miss_sum[CW-1:0];
		evict_next = evict_sum[CW] ? {CW{1'b1}} : evict_sum[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			done        <= 1'b0;
		end else begin
			done <= state_q == salc_pkg::ST_LOOKUP;
			if (state_q == salc_pkg::ST_LOOKUP) begin
				hit_cnt_q   <= hit_next;
				miss_cnt_q  <= miss_next;
				evict_cnt_q <= evict_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == salc_pkg::ST_LOOKUP) begin
			result.was_hit          <= req_ok && flags.hit;
			result.was_miss         <= req_ok && flags.miss;
			result.was_eviction     <= req_ok && flags.evict;
			result.second_hit       <= is_modify;
			result.hits_so_far      <= hit_next;
			result.misses_so_far    <= miss_next;
			result.evictions_so_far <= evict_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/salc_checker.sv
`default_nettype none

module salc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire salc_pkg::salc_out_t result
);

	// every accepted request gets its result strobe after the lookup state
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("missing result after request");

	// requests are spaced, so results never come back to back
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted while lookup pending");

	a_flag_consistency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.was_hit && result.was_miss)
			&& (!result.was_eviction || result.was_miss)
			&& (!result.second_hit || result.was_hit || result.was_miss))
		else $error("inconsistent result flags");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);

`default_nettype wire

>>> tb/set_assoc_lru_cache_sim_tb.sv
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_tb;

	localparam int MAX_SET_BITS   = 6;
	localparam int MAX_WAYS       = 8;
	localparam int NUM_SETS       = 1 << MAX_SET_BITS;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 150;

	localparam logic [1:0]                 REQ_UNKNOWN = 2'd3;
	localparam logic [salc_pkg::CNT_W-1:0] CNT_MAX     = '1;

	typedef enum logic [1:0] {
		OP_ACCESS,
		OP_CONFIG,
		OP_SETTLE
	} op_kind_t;

	typedef struct packed {
		op_kind_t                       kind;
		salc_pkg::salc_in_t             req;
		logic [salc_pkg::CFG_IDX_W-1:0] idx;
		logic [salc_pkg::CFG_W-1:0]     data;
	} stim_op_t;

	typedef enum logic [1:0] {
		ACC_HIT,
		ACC_FILL,
		ACC_EVICT
	} access_t;

	logic                           clk;
	logic                           arst_n   = 1'b0;
	logic                           start    = 1'b0;
	logic                           busy;
	salc_pkg::salc_in_t             req      = '0;
	logic                           done;
	salc_pkg::salc_out_t            result;
	logic                           wr_en    = 1'b0;
	logic [salc_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [salc_pkg::CFG_W-1:0]     wr_data  = '0;

	set_assoc_lru_cache_sim dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// tag array shadow
	logic        cache_valid [NUM_SETS][MAX_WAYS] = '{default: '0};
	logic [61:0] cache_tag   [NUM_SETS][MAX_WAYS] = '{default: '0};
	logic [2:0]  cache_rank  [NUM_SETS][MAX_WAYS] = '{default: '0};
	logic [salc_pkg::CNT_W-1:0] hit_tally   = '0;
	logic [salc_pkg::CNT_W-1:0] miss_tally  = '0;
	logic [salc_pkg::CNT_W-1:0] evict_tally = '0;
	logic [2:0] cfg_set_bits = salc_pkg::SET_BITS_RESET;
	logic [3:0] cfg_ways     = salc_pkg::WAYS_IN_USE_RESET;
	logic [5:0] cfg_offset   = salc_pkg::OFFSET_BITS_RESET;

	salc_pkg::salc_out_t cache_outcomes_due [$];
	stim_op_t            op_queue [$];

	int gen_s = salc_pkg::SET_BITS_RESET;
	int gen_w = salc_pkg::WAYS_IN_USE_RESET;
	int gen_o = salc_pkg::OFFSET_BITS_RESET;

	int  gap_left       = 0;
	int  burst_left     = 0;
	int  quiet_cycles   = 0;
	int  stall_cycles   = 0;
	int  mismatch_count = 0;
	logic stim_finished = 1'b0;

	function automatic int sat_range(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void promote_way(int set_idx, int way, int w, int old_rank);
		for (int i = 0; i < w; i++) begin
			if (i != way && cache_valid[set_idx][i] && cache_rank[set_idx][i] < old_rank &&
					cache_rank[set_idx][i] < MAX_WAYS - 1)
				cache_rank[set_idx][i] = cache_rank[set_idx][i] + 3'd1;
		end
		cache_rank[set_idx][way] = '0;
	endfunction

	function automatic access_t lookup_line(int set_idx, logic [61:0] tg, int w);
		int nvalid;
		int free_way;
		int victim;
		int top;
		bit have_free;
		nvalid = 0;
		free_way = 0;
		victim = 0;
		top = 0;
		have_free = 1'b0;
		for (int i = 0; i < w; i++) begin
			if (cache_valid[set_idx][i]) begin
				if (cache_tag[set_idx][i] == tg) begin
					if (hit_tally != CNT_MAX)
						hit_tally++;
					promote_way(set_idx, i, w, cache_rank[set_idx][i]);
					return ACC_HIT;
				end
				nvalid++;
			end else begin
				have_free = 1'b1;
				free_way = i;
			end
		end
		if (miss_tally != CNT_MAX)
			miss_tally++;
		if (have_free) begin
			cache_valid[set_idx][free_way] = 1'b1;
			cache_tag[set_idx][free_way] = tg;
			promote_way(set_idx, free_way, w, nvalid);
			return ACC_FILL;
		end
		if (evict_tally != CNT_MAX)
			evict_tally++;
		// lowest-numbered way wins among equal ranks
		for (int i = 0; i < w; i++) begin
			if (cache_rank[set_idx][i] > top) begin
				top = cache_rank[set_idx][i];
				victim = i;
			end
		end
		cache_tag[set_idx][victim] = tg;
		promote_way(set_idx, victim, w, MAX_WAYS);
		return ACC_EVICT;
	endfunction

	function automatic salc_pkg::salc_out_t predict_access(salc_pkg::salc_in_t r);
		int s;
		int o;
		int w;
		int set_idx;
		logic [61:0] tg;
		access_t first;
		salc_pkg::salc_out_t res;
		s = sat_range(cfg_set_bits, 1, MAX_SET_BITS);
		o = sat_range(cfg_offset, 1, salc_pkg::OFFSET_BITS_MAX);
		w = sat_range(cfg_ways, 1, MAX_WAYS);
		set_idx = int'((r.address >> o) & ((64'd1 << s) - 64'd1));
		tg = 62'(r.address >> (o + s));
		res = '0;
		if (r.req_type != REQ_UNKNOWN) begin
			first = lookup_line(set_idx, tg, w);
			res.was_hit = (first == ACC_HIT);
			res.was_miss = (first != ACC_HIT);
			res.was_eviction = (first == ACC_EVICT);
			if (r.req_type == salc_pkg::REQ_MODIFY)
				res.second_hit = (lookup_line(set_idx, tg, w) == ACC_HIT);
		end
		res.hits_so_far = hit_tally;
		res.misses_so_far = miss_tally;
		res.evictions_so_far = evict_tally;
		return res;
	endfunction

	function automatic logic [63:0] line_addr(int set_idx, logic [63:0] tg);
		logic [63:0] low;
		low = {$urandom, $urandom} & ((64'd1 << gen_o) - 64'd1);
		return (tg << (gen_o + gen_s)) | (64'(set_idx) << gen_o) | low;
	endfunction

	task automatic queue_access(logic [1:0] kind, logic [63:0] addr);
		stim_op_t op;
		op = '0;
		op.kind = OP_ACCESS;
		op.req.req_type = kind;
		op.req.address = addr;
		op_queue.push_back(op);
	endtask

	task automatic queue_settle();
		stim_op_t op;
		op = '0;
		op.kind = OP_SETTLE;
		op_queue.push_back(op);
	endtask

	task automatic queue_config(logic [salc_pkg::CFG_IDX_W-1:0] idx,
			logic [salc_pkg::CFG_W-1:0] data);
		stim_op_t op;
		op = '0;
		op.kind = OP_CONFIG;
		op.idx = idx;
		op.data = data;
		queue_settle();
		op_queue.push_back(op);
		case (idx)
			salc_pkg::REG_SET_BITS:    gen_s = sat_range(data[2:0], 1, MAX_SET_BITS);
			salc_pkg::REG_WAYS_IN_USE: gen_w = sat_range(data[3:0], 1, MAX_WAYS);
			salc_pkg::REG_OFFSET_BITS: gen_o = sat_range(data, 1, salc_pkg::OFFSET_BITS_MAX);
			default: ;
		endcase
	endtask

	task automatic queue_random_phase(int n);
		int settle_at;
		int roll;
		int set_idx;
		settle_at = $urandom_range(20, n - 20);
		for (int i = 0; i < n; i++) begin
			if (i == settle_at)
				queue_settle();
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				set_idx = $urandom_range(0, (1 << gen_s) - 1);
			else
				set_idx = $urandom_range(0, sat_range((1 << gen_s) - 1, 0, 3));
			if (roll < 80)
				queue_access(2'($urandom_range(0, 2)),
					line_addr(set_idx, 64'($urandom_range(0, gen_w + 3))));
			else if (roll < 97)
				queue_access(2'($urandom_range(0, 2)), {$urandom, $urandom});
			else
				queue_access(REQ_UNKNOWN, {$urandom, $urandom});
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin : drive
		logic go;
		logic cfg_go;
		go = 1'b0;
		cfg_go = 1'b0;
		if (arst_n) begin
			if (start && !busy)
				cache_outcomes_due.push_back(predict_access(req));
			if (wr_en) begin
				case (wr_index)
					salc_pkg::REG_SET_BITS:    cfg_set_bits = wr_data[2:0];
					salc_pkg::REG_WAYS_IN_USE: cfg_ways = wr_data[3:0];
					salc_pkg::REG_OFFSET_BITS: cfg_offset = wr_data;
					default: ;
				endcase
			end
			if (cache_outcomes_due.size() == 0 && !busy && !start)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (start && busy) begin
				go = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (op_queue.size() > 0) begin
				case (op_queue[0].kind)
					OP_ACCESS: begin
						req <= op_queue[0].req;
						go = 1'b1;
						op_queue.pop_front();
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
						end
					end
					OP_CONFIG: begin
						wr_index <= op_queue[0].idx;
						wr_data <= op_queue[0].data;
						cfg_go = 1'b1;
						op_queue.pop_front();
					end
					OP_SETTLE: begin
						if (quiet_cycles >= SETTLE_CYCLES)
							op_queue.pop_front();
					end
					default: op_queue.pop_front();
				endcase
			end else begin
				stim_finished <= 1'b1;
			end
		end
		start <= go;
		wr_en <= cfg_go;
	end

	// result checker
	always @(posedge clk) begin : check
		salc_pkg::salc_out_t want;
		if (arst_n && done) begin
			if (cache_outcomes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result at %0t: hit=%0b miss=%0b evict=%0b", $realtime,
						result.was_hit, result.was_miss, result.was_eviction);
			end else begin
				want = cache_outcomes_due.pop_front();
				if (result.was_hit !== want.was_hit || result.was_miss !== want.was_miss ||
						result.was_eviction !== want.was_eviction ||
						result.second_hit !== want.second_hit ||
						result.hits_so_far !== want.hits_so_far ||
						result.misses_so_far !== want.misses_so_far ||
						result.evictions_so_far !== want.evictions_so_far) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch at %0t: exp h/m/e/h2=%0b%0b%0b%0b tot=%0d/%0d/%0d,",
							$realtime, want.was_hit, want.was_miss, want.was_eviction,
							want.second_hit, want.hits_so_far, want.misses_so_far,
							want.evictions_so_far,
							" got h/m/e/h2=%0b%0b%0b%0b tot=%0d/%0d/%0d",
							result.was_hit, result.was_miss,
							result.was_eviction, result.second_hit, result.hits_so_far,
							result.misses_so_far, result.evictions_so_far);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("set_assoc_lru_cache_sim test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// reset config: 16 sets, 8 ways, 16-byte lines
		queue_access(salc_pkg::REQ_LOAD, 64'h0);
		queue_access(salc_pkg::REQ_LOAD, 64'h8);
		queue_access(salc_pkg::REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_access(salc_pkg::REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0);
		queue_access(salc_pkg::REQ_MODIFY, line_addr(3, 64'd5));
		queue_access(REQ_UNKNOWN, 64'h0);
		// fill one set, then evict the oldest line
		for (int t = 1; t <= 9; t++)
			queue_access(salc_pkg::REQ_LOAD, line_addr(1, 64'(t)));
		queue_access(salc_pkg::REQ_LOAD, line_addr(1, 64'd1));
		queue_access(salc_pkg::REQ_STORE, line_addr(1, 64'd9));
		// out-of-range low values clamp to the minimum
		queue_config(salc_pkg::REG_SET_BITS, 6'd0);
		queue_config(salc_pkg::REG_WAYS_IN_USE, 6'd0);
		queue_config(salc_pkg::REG_OFFSET_BITS, 6'd0);
		queue_access(salc_pkg::REQ_LOAD, 64'h0);
		queue_access(salc_pkg::REQ_LOAD, 64'h4);
		queue_access(salc_pkg::REQ_MODIFY, 64'h2);
		// out-of-range high values clamp to the maximum
		queue_config(salc_pkg::REG_SET_BITS, 6'd15);
		queue_config(salc_pkg::REG_WAYS_IN_USE, 6'd15);
		queue_config(salc_pkg::REG_OFFSET_BITS, 6'd63);
		queue_access(salc_pkg::REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_access(salc_pkg::REQ_LOAD, 64'h1 << 38);
		queue_access(salc_pkg::REQ_MODIFY, (64'h1 << 38) | (64'h1 << 32));
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0) begin
				queue_config(salc_pkg::REG_SET_BITS, 6'd6);
				queue_config(salc_pkg::REG_WAYS_IN_USE, 6'd8);
				queue_config(salc_pkg::REG_OFFSET_BITS, 6'd32);
			end else if (ph == 1) begin
				queue_config(salc_pkg::REG_SET_BITS, 6'd1);
				queue_config(salc_pkg::REG_WAYS_IN_USE, 6'd1);
				queue_config(salc_pkg::REG_OFFSET_BITS, 6'd1);
			end else begin
				queue_config(salc_pkg::REG_SET_BITS, ($urandom_range(0, 4) == 0) ?
					6'($urandom) : 6'($urandom_range(1, 6)));
				queue_config(salc_pkg::REG_WAYS_IN_USE, ($urandom_range(0, 4) == 0) ?
					6'($urandom_range(0, 15)) : 6'($urandom_range(1, 8)));
				queue_config(salc_pkg::REG_OFFSET_BITS, ($urandom_range(0, 4) == 0) ?
					6'($urandom) : 6'($urandom_range(1, 8)));
			end
			queue_random_phase(PHASE_ITEMS);
		end
		queue_settle();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_finished);
		@(posedge clk);
		if (mismatch_count == 0 && cache_outcomes_due.size() == 0)
			$display("set_assoc_lru_cache_sim test passed");
		else
			$display("set_assoc_lru_cache_sim test failed");
		$finish;
	end

endmodule
